### rtl/bipartite_max_matching_independent_set_core_macros.svh
// Assertion macros shared by the matching core.
`ifndef BIPARTITE_MAX_MATCHING_INDEPENDENT_SET_CORE_MACROS_SVH
`define BIPARTITE_MAX_MATCHING_INDEPENDENT_SET_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMIS_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("check failed");
`define BMIS_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error("check failed");
`else
`define BMIS_ASSERT(lbl, ck, rn, prop)
`define BMIS_NEVER(lbl, ck, rn, cond)
`endif
`endif

### rtl/bmis_pkg.sv
// Shared constants and types of the matching core.
package bmis_pkg;
    localparam int MAX_VERTICES_DEF = 512;
    localparam int MAX_DEGREE_DEF   = 64;
    localparam int KIND_W           = 2;

    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;
endpackage

### rtl/bmis_ram.sv
// Generic simple dual-port RAM with registered read.
module bmis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/bmis_engine.sv
// Graph store and augmenting-path search sequencer.
`include "bipartite_max_matching_independent_set_core_macros.svh"
module bmis_engine
    import bmis_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
    localparam int VW  = $clog2(MAX_VERTICES),
    localparam int CW  = $clog2(MAX_VERTICES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  logic [VW-1:0]     vertex,
    input  logic [VW-1:0]     neighbor,
    input  logic [CW-1:0]     vertex_count,
    input  logic              hold,
    output eng_status_t       status,
    output logic [CW-1:0]     res_ind,
    output logic [CW-1:0]     res_mat,
    output logic              res_ovf
);
    localparam int DW   = $clog2(MAX_DEGREE + 1);
    localparam int ADEP = MAX_VERTICES * MAX_DEGREE;
    localparam int AAW  = $clog2(ADEP);
    localparam int SDEP = MAX_VERTICES + 1;
    localparam int SAW  = $clog2(SDEP);
    localparam int SWW  = VW + DW + DW + VW;
    localparam int PWW  = VW + 1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_CLR_DEG = 12'b000000000010,
        ST_ADD     = 12'b000000000100,
        ST_CLR_SOL = 12'b000000001000,
        ST_START   = 12'b000000010000,
        ST_DEG     = 12'b000000100000,
        ST_EXAM    = 12'b000001000000,
        ST_ADJ     = 12'b000010000000,
        ST_VIS     = 12'b000100000000,
        ST_POP     = 12'b001000000000,
        ST_UNW     = 12'b010000000000,
        ST_FIN     = 12'b100000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] mat_reg, mat_next;
    logic [SAW-1:0] top_reg, top_next;
    logic [VW-1:0] u_reg, u_next;
    logic [DW-1:0] nxt_reg, nxt_next;
    logic [DW-1:0] deg_reg, deg_next;
    logic [VW-1:0] y_reg, y_next;
    logic [VW-1:0] av_reg, av_next;
    logic [VW-1:0] an_reg, an_next;
    logic          done;

    logic          deg_we;
    logic [VW-1:0] deg_waddr, deg_raddr;
    logic [DW-1:0] deg_wdata, deg_rdata;
    logic          adj_we;
    logic [AAW-1:0] adj_waddr, adj_raddr;
    logic [VW-1:0] adj_wdata, adj_rdata;
    logic          vis_we;
    logic [VW-1:0] vis_waddr, vis_raddr;
    logic [CW-1:0] vis_wdata, vis_rdata;
    logic          par_we;
    logic [VW-1:0] par_waddr, par_raddr;
    logic [PWW-1:0] par_wdata, par_rdata;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [SWW-1:0] stk_wdata, stk_rdata;

    logic [VW-1:0] stk_u, stk_y;
    logic [DW-1:0] stk_nxt, stk_deg;
    logic [CW-1:0] stamp;

    assign stk_u   = stk_rdata[SWW-1 -: VW];
    assign stk_nxt = stk_rdata[VW+DW+DW-1 -: DW];
    assign stk_deg = stk_rdata[VW+DW-1 -: DW];
    assign stk_y   = stk_rdata[VW-1:0];
    assign stamp   = idx_reg + CW'(1);

    bmis_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );
    bmis_ram #(.WIDTH(VW), .DEPTH(ADEP)) u_adj_ram (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );
    bmis_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_vis_ram (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );
    bmis_ram #(.WIDTH(PWW), .DEPTH(MAX_VERTICES)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    bmis_ram #(.WIDTH(SWW), .DEPTH(SDEP)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        mat_next   = mat_reg;
        top_next   = top_reg;
        u_next     = u_reg;
        nxt_next   = nxt_reg;
        deg_next   = deg_reg;
        y_next     = y_reg;
        av_next    = av_reg;
        an_next    = an_reg;
        done       = 1'b0;
        deg_we = 1'b0; deg_waddr = clr_reg; deg_wdata = '0; deg_raddr = vertex;
        adj_we = 1'b0; adj_waddr = '0; adj_wdata = an_reg; adj_raddr = '0;
        vis_we = 1'b0; vis_waddr = clr_reg; vis_wdata = '0; vis_raddr = adj_rdata;
        par_we = 1'b0; par_waddr = clr_reg; par_wdata = '0; par_raddr = adj_rdata;
        stk_we = 1'b0; stk_waddr = top_reg; stk_wdata = {u_reg, nxt_reg, deg_reg, y_reg};
        stk_raddr = top_reg - SAW'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_BEGIN:
                        begin
                            cnt_next = (vertex_count > CW'(MAX_VERTICES)) ?
                                       CW'(MAX_VERTICES) : vertex_count;
                            ovf_next   = 1'b0;
                            clr_next   = '0;
                            state_next = ST_CLR_DEG;
                        end
                        KIND_ADD:
                        begin
                            if ((CW'(vertex) < cnt_reg) && (CW'(neighbor) < cnt_reg))
                            begin
                                av_next    = vertex;
                                an_next    = neighbor;
                                state_next = ST_ADD;
                            end
                        end
                        KIND_SOLVE:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR_SOL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLR_DEG:
            begin
                deg_we   = 1'b1;
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                if (deg_rdata >= DW'(MAX_DEGREE))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    adj_we    = 1'b1;
                    adj_waddr = AAW'(av_reg) * AAW'(MAX_DEGREE) + AAW'(deg_rdata);
                    deg_we    = 1'b1;
                    deg_waddr = av_reg;
                    deg_wdata = deg_rdata + DW'(1);
                end
                state_next = ST_IDLE;
            end
            ST_CLR_SOL:
            begin
                vis_we   = 1'b1;
                par_we   = 1'b1;
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1))
                begin
                    idx_next   = '0;
                    mat_next   = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    u_next     = idx_reg[VW-1:0];
                    nxt_next   = '0;
                    top_next   = '0;
                    deg_raddr  = idx_reg[VW-1:0];
                    state_next = ST_DEG;
                end
            end
            ST_DEG:
            begin
                deg_next   = deg_rdata;
                state_next = ST_EXAM;
            end
            ST_EXAM:
            begin
                if (nxt_reg < deg_reg)
                begin
                    adj_raddr  = AAW'(u_reg) * AAW'(MAX_DEGREE) + AAW'(nxt_reg);
                    nxt_next   = nxt_reg + DW'(1);
                    state_next = ST_ADJ;
                end
                else if (top_reg == '0)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_START;
                end
                else
                begin
                    top_next   = top_reg - SAW'(1);
                    state_next = ST_POP;
                end
            end
            ST_ADJ:
            begin
                y_next = adj_rdata;
                if (CW'(adj_rdata) < cnt_reg)
                begin
                    state_next = ST_VIS;
                end
                else
                begin
                    state_next = ST_EXAM;
                end
            end
            ST_VIS:
            begin
                if (vis_rdata == stamp)
                begin
                    state_next = ST_EXAM;
                end
                else
                begin
                    vis_we    = 1'b1;
                    vis_waddr = y_reg;
                    vis_wdata = stamp;
                    if (!par_rdata[VW])
                    begin
                        par_we    = 1'b1;
                        par_waddr = y_reg;
                        par_wdata = {1'b1, u_reg};
                        mat_next  = mat_reg + CW'(1);
                        if (top_reg == '0)
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = ST_START;
                        end
                        else
                        begin
                            top_next   = top_reg - SAW'(1);
                            state_next = ST_UNW;
                        end
                    end
                    else if (top_reg == SAW'(SDEP - 1))
                    begin
                        state_next = ST_EXAM;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        top_next   = top_reg + SAW'(1);
                        u_next     = par_rdata[VW-1:0];
                        nxt_next   = '0;
                        deg_raddr  = par_rdata[VW-1:0];
                        state_next = ST_DEG;
                    end
                end
            end
            ST_POP:
            begin
                u_next     = stk_u;
                nxt_next   = stk_nxt;
                deg_next   = stk_deg;
                state_next = ST_EXAM;
            end
            ST_UNW:
            begin
                par_we    = 1'b1;
                par_waddr = stk_y;
                par_wdata = {1'b1, stk_u};
                if (top_reg == '0)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_START;
                end
                else
                begin
                    top_next = top_reg - SAW'(1);
                end
            end
            ST_FIN:
            begin
                if (!hold)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_EXAM || state_reg == ST_VIS)
        begin
            stk_raddr = top_reg - SAW'(1);
        end
        else if (state_reg == ST_UNW)
        begin
            stk_raddr = top_reg - SAW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            clr_reg   <= '0;
            idx_reg   <= '0;
            mat_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            mat_reg   <= mat_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        nxt_reg <= nxt_next;
        deg_reg <= deg_next;
        y_reg   <= y_next;
        av_reg  <= av_next;
        an_reg  <= an_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done;
    assign res_mat     = mat_reg;
    assign res_ind     = cnt_reg - (mat_reg >> 1);
    assign res_ovf     = ovf_reg;

    `BMIS_NEVER(a_done_while_held, clk, rst_n, done && hold)
    `BMIS_ASSERT(a_mat_bounded, clk, rst_n, mat_reg <= idx_reg + CW'(1))
    `BMIS_ASSERT(a_count_bounded, clk, rst_n, cnt_reg <= CW'(MAX_VERTICES))
    `BMIS_ASSERT(a_start_from_idle, clk, rst_n, (state_reg == ST_START) |=> (state_reg == ST_DEG) || (state_reg == ST_FIN))
endmodule

### rtl/bipartite_max_matching_independent_set_core.sv
// Top level of the maximum matching and independent set core.
// Begin sweeps the degree store to clear it; an add stores an edge unless its vertex degree is full.
// A solve first clears the partner and visited stores, then searches from each start vertex,
// examining its edges, popping the stack and unwinding levels.
// One item is worked at a time; a finished result waits in an output register.
// Reset clears control state; the graph is empty until the first begin beat.
module bipartite_max_matching_independent_set_core
    import bmis_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [VW-1:0]     vertex,
    input  logic [VW-1:0]     neighbor,
    input  logic [CW-1:0]     vertex_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CW-1:0]     independent_set_size,
    output logic [CW-1:0]     matching_size,
    output logic              degree_overflow
);
    eng_status_t   status;
    logic [CW-1:0] res_ind, res_mat;
    logic          res_ovf;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] ind_reg, mat_reg;
    logic          ovf_reg;

    assign in_ready = !status.busy;

    bmis_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_engine (
        .clk(clk), .rst_n(rst_n), .start(in_valid && in_ready), .kind(kind),
        .vertex(vertex), .neighbor(neighbor), .vertex_count(vertex_count),
        .hold(out_valid_reg), .status(status), .res_ind(res_ind),
        .res_mat(res_mat), .res_ovf(res_ovf)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            ind_reg <= res_ind;
            mat_reg <= res_mat;
            ovf_reg <= res_ovf;
        end
    end

    assign out_valid            = out_valid_reg;
    assign independent_set_size = ind_reg;
    assign matching_size        = mat_reg;
    assign degree_overflow      = ovf_reg;
endmodule
